@@ hw/rtl/dpcm_pkg.sv @@
// ----------------------------------------------------------------------------
// dpcm_pkg: shared types and constants for the delta PCM sample channel
// Item and result layouts, operation and register codes, the bit period table.
// ----------------------------------------------------------------------------
package dpcm_pkg;

    // Operation carried by an input item
    typedef enum logic [1:0] {
        OP_REG_WRITE  = 2'd0,
        OP_CTRL_WRITE = 2'd1,
        OP_TICK       = 2'd2
    } op_t;

    // Channel register targets of a register write
    typedef enum logic [1:0] {
        REG_RATE   = 2'd0,
        REG_LEVEL  = 2'd1,
        REG_START  = 2'd2,
        REG_LENGTH = 2'd3
    } reg_idx_t;

    localparam int unsigned RATE_W  = 22;
    localparam int unsigned PHASE_W = 26;
    localparam int unsigned BITS_W  = 15;
    localparam int unsigned ADDR_W  = 16;

    localparam logic [RATE_W-1:0] PHASE_STEP_RESET = 22'd265664;
    localparam logic [RATE_W-1:0] PHASE_STEP_MAX   = 22'd3538943;
    localparam logic [ADDR_W-1:0] START_BASE       = 16'hC000;
    localparam logic [ADDR_W-1:0] ADDR_LAST        = 16'hFFFF;
    localparam logic [ADDR_W-1:0] ADDR_WRAP        = 16'h8000;
    localparam logic [5:0]        LEVEL_MAX        = 6'h3F;
    localparam logic [5:0]        LEVEL_MIN        = 6'd1;

    // One input item as held in the input register
    typedef struct packed {
        logic [1:0] op;
        logic [1:0] reg_index;
        logic [7:0] write_data;
        logic [7:0] mem_byte;
    } item_t;

    // One result item
    typedef struct packed {
        logic              fetch_due;
        logic [ADDR_W-1:0] fetch_address;
        logic              sample_valid;
        logic [6:0]        sample;
    } result_t;

    // Bit period in clock units, indexed by rate
    function automatic logic [8:0] bit_period(input logic [3:0] idx);
        logic [8:0] p;
        case (idx)
            4'd0:    p = 9'd428;
            4'd1:    p = 9'd380;
            4'd2:    p = 9'd340;
            4'd3:    p = 9'd320;
            4'd4:    p = 9'd286;
            4'd5:    p = 9'd254;
            4'd6:    p = 9'd226;
            4'd7:    p = 9'd214;
            4'd8:    p = 9'd190;
            4'd9:    p = 9'd160;
            4'd10:   p = 9'd142;
            4'd11:   p = 9'd128;
            4'd12:   p = 9'd106;
            4'd13:   p = 9'd85;
            4'd14:   p = 9'd72;
            default: p = 9'd54;
        endcase
        return p;
    endfunction

endpackage

@@ hw/rtl/dpcm_core.sv @@
// ----------------------------------------------------------------------------
// dpcm_core: channel state and single-pass item update
// Holds all channel state and computes the new state and result of one item.
// ----------------------------------------------------------------------------
module dpcm_core (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     cfg_wr_en,
    input  logic [21:0]              cfg_wr_data,
    input  logic                     advance,
    input  dpcm_pkg::item_t          item,
    output dpcm_pkg::result_t        result
);

    logic [21:0] phase_step_reg;
    logic        ctrl_enable_reg,     ctrl_enable_next;
    logic        loop_flag_reg,       loop_flag_next;
    logic [3:0]  rate_index_reg,      rate_index_next;
    logic        reg_one_low_bit_reg, reg_one_low_bit_next;
    logic [5:0]  level_reg,           level_next;
    logic [7:0]  shift_byte_reg,      shift_byte_next;
    logic [15:0] read_address_reg,    read_address_next;
    logic [15:0] start_address_reg,   start_address_next;
    logic [14:0] bits_left_reg,       bits_left_next;
    logic [14:0] reload_length_reg,   reload_length_next;
    logic [25:0] phase_reg,           phase_next;

    logic [25:0] phase_sub;
    logic [25:0] period_ext;
    logic [14:0] bits_dec;
    logic        move_level;
    logic [2:0]  bit_sel;
    logic        data_bit;

    // Configuration register, clamped so that one tick consumes at most one bit
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_step_reg <= dpcm_pkg::PHASE_STEP_RESET;
        end else if (cfg_wr_en) begin
            phase_step_reg <= (cfg_wr_data > dpcm_pkg::PHASE_STEP_MAX) ?
                              dpcm_pkg::PHASE_STEP_MAX : cfg_wr_data;
        end
    end

    assign phase_sub  = phase_reg - {4'd0, phase_step_reg};
    assign period_ext = {1'b0, dpcm_pkg::bit_period(rate_index_reg), 16'd0};

    // Next state for one item
    always_comb begin
        ctrl_enable_next     = ctrl_enable_reg;
        loop_flag_next       = loop_flag_reg;
        rate_index_next      = rate_index_reg;
        reg_one_low_bit_next = reg_one_low_bit_reg;
        level_next           = level_reg;
        shift_byte_next      = shift_byte_reg;
        read_address_next    = read_address_reg;
        start_address_next   = start_address_reg;
        bits_left_next       = bits_left_reg;
        reload_length_next   = reload_length_reg;
        phase_next           = phase_reg;
        bits_dec             = bits_left_reg - 15'd1;
        move_level           = 1'b0;
        bit_sel              = 3'd0;
        data_bit             = 1'b0;

        case (dpcm_pkg::op_t'(item.op))
            dpcm_pkg::OP_REG_WRITE: begin
                case (dpcm_pkg::reg_idx_t'(item.reg_index))
                    dpcm_pkg::REG_RATE: begin
                        rate_index_next = item.write_data[3:0];
                        loop_flag_next  = item.write_data[6];
                    end
                    dpcm_pkg::REG_LEVEL: begin
                        level_next           = item.write_data[6:1];
                        reg_one_low_bit_next = item.write_data[0];
                    end
                    dpcm_pkg::REG_START: begin
                        start_address_next = dpcm_pkg::START_BASE
                                           + {2'd0, item.write_data, 6'd0};
                    end
                    default: begin
                        reload_length_next = {item.write_data, 7'b0001000};
                    end
                endcase
            end
            dpcm_pkg::OP_CTRL_WRITE: begin
                ctrl_enable_next = item.write_data[4];
                if (!item.write_data[4]) begin
                    bits_left_next = '0;
                end else if (bits_left_reg == '0) begin
                    read_address_next = start_address_reg;
                    bits_left_next    = reload_length_reg;
                end
            end
            dpcm_pkg::OP_TICK: begin
                if (bits_left_reg != '0) begin
                    if (phase_sub[25]) begin
                        phase_next = phase_sub + period_ext;
                        // byte boundary: take the fetched byte, advance address
                        if (bits_left_reg[2:0] == 3'd0) begin
                            shift_byte_next   = item.mem_byte;
                            read_address_next = (read_address_reg == dpcm_pkg::ADDR_LAST) ?
                                                dpcm_pkg::ADDR_WRAP :
                                                read_address_reg + 16'd1;
                        end
                        // end of data: loop or stop
                        if (bits_dec == '0) begin
                            if (loop_flag_reg) begin
                                read_address_next = start_address_reg;
                                bits_left_next    = reload_length_reg;
                                move_level        = 1'b1;
                            end else begin
                                bits_left_next = '0;
                            end
                        end else begin
                            bits_left_next = bits_dec;
                            move_level     = 1'b1;
                        end
                        bit_sel  = ~bits_left_next[2:0];
                        data_bit = shift_byte_next[bit_sel];
                        if (move_level) begin
                            if (data_bit) begin
                                if (level_reg < dpcm_pkg::LEVEL_MAX) begin
                                    level_next = level_reg + 6'd1;
                                end
                            end else if (level_reg > dpcm_pkg::LEVEL_MIN) begin
                                level_next = level_reg - 6'd1;
                            end
                        end
                    end else begin
                        phase_next = phase_sub;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // Result reflects the state after the item
    always_comb begin
        result.sample        = {level_next, reg_one_low_bit_next};
        result.sample_valid  = (dpcm_pkg::op_t'(item.op) == dpcm_pkg::OP_TICK)
                               && ctrl_enable_next;
        result.fetch_address = read_address_next;
        result.fetch_due     = (bits_left_next != '0) && (bits_left_next[2:0] == 3'd0);
    end

    // Channel state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctrl_enable_reg     <= 1'b0;
            loop_flag_reg       <= 1'b0;
            rate_index_reg      <= '0;
            reg_one_low_bit_reg <= 1'b0;
            level_reg           <= '0;
            shift_byte_reg      <= '0;
            read_address_reg    <= '0;
            start_address_reg   <= '0;
            bits_left_reg       <= '0;
            reload_length_reg   <= '0;
            phase_reg           <= '0;
        end else if (advance) begin
            ctrl_enable_reg     <= ctrl_enable_next;
            loop_flag_reg       <= loop_flag_next;
            rate_index_reg      <= rate_index_next;
            reg_one_low_bit_reg <= reg_one_low_bit_next;
            level_reg           <= level_next;
            shift_byte_reg      <= shift_byte_next;
            read_address_reg    <= read_address_next;
            start_address_reg   <= start_address_next;
            bits_left_reg       <= bits_left_next;
            reload_length_reg   <= reload_length_next;
            phase_reg           <= phase_next;
        end
    end

    // Phase accumulator never goes negative between items
    a_phase_nonneg: assert property (@(posedge aclk) disable iff (!aresetn)
        !phase_reg[25])
        else $error("phase accumulator negative");

    // A disabled channel holds no pending bits
    a_off_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        !ctrl_enable_reg |-> (bits_left_reg == '0))
        else $error("bits pending while channel disabled");

    // An idle tick leaves the phase alone
    a_idle_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && (item.op == dpcm_pkg::OP_TICK) && (bits_left_reg == '0)
        |=> $stable(phase_reg))
        else $error("phase moved on idle tick");

    // A tick moves the level by at most one step
    a_level_step: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && (item.op == dpcm_pkg::OP_TICK)
        |=> (level_reg == $past(level_reg)) || (level_reg == $past(level_reg) + 6'd1)
            || (level_reg == $past(level_reg) - 6'd1))
        else $error("level jumped on tick");

endmodule

@@ hw/rtl/delta_pcm_sample_channel.sv @@
// ----------------------------------------------------------------------------
// delta_pcm_sample_channel: 1-bit delta-modulation sample channel
// Streaming wrapper: input register, channel core, result register.
// ----------------------------------------------------------------------------
// Every input item (register write, control write or sample tick) yields one
// result item carrying the 7-bit sample, a sample-valid flag, the address whose
// byte the next tick must carry and whether that tick will fetch it. Items pass
// an input register, combinational channel update logic and a result register;
// one item is taken per cycle unless the result side stalls, and the channel state
// update of one item is combinational. The phase step may only be written while
// no item is in flight.
module delta_pcm_sample_channel (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration
    input  logic        cfg_wr_en,
    input  logic [21:0] cfg_wr_data,     // phase step per tick
    // input items
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,    // [1:0] reg_index, [9:2] write_data,
                                         // [17:10] mem_byte, [23:18] zero
    input  logic [1:0]  s_axis_tuser,    // [1:0] op
    // result items
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,    // [6:0] sample, [22:7] fetch_address,
                                         // [23] fetch_due
    output logic [0:0]  m_axis_tuser     // [0] sample_valid
);

    logic              in_valid_reg, in_valid_next;
    dpcm_pkg::item_t   in_item_reg;
    logic              out_valid_reg, out_valid_next;
    dpcm_pkg::result_t out_result_reg;
    dpcm_pkg::result_t core_result;
    logic              advance;
    logic              s_accept;

    // Handshake: item moves on when the result register is free or draining
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign s_accept      = s_axis_tvalid && s_axis_tready;

    assign in_valid_next  = s_accept || (in_valid_reg && !advance);
    assign out_valid_next = advance || (out_valid_reg && !m_axis_tready);

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Input item register
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_item_reg.op         <= s_axis_tuser;
            in_item_reg.reg_index  <= s_axis_tdata[1:0];
            in_item_reg.write_data <= s_axis_tdata[9:2];
            in_item_reg.mem_byte   <= s_axis_tdata[17:10];
        end
    end

    dpcm_core u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .advance     (advance),
        .item        (in_item_reg),
        .result      (core_result)
    );

    // Result register
    always_ff @(posedge aclk) begin
        if (advance) begin
            out_result_reg <= core_result;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_result_reg.fetch_due, out_result_reg.fetch_address,
                            out_result_reg.sample};
    assign m_axis_tuser  = out_result_reg.sample_valid;

endmodule

@@ dv/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench: stream-level test of the delta PCM sample channel
// Drives register writes, control writes and sample ticks with random gaps
// and back-pressure, predicts every result item from its own channel model
// and checks each one field by field, in order.
// ----------------------------------------------------------------------------
module testbench;

    localparam logic [1:0] OP_UNUSED   = 2'd3;   // op code with no meaning
    localparam int unsigned STALL_LIMIT = 2000;  // cycles with no item moving
    localparam int unsigned PRINT_LIMIT = 40;    // mismatch lines printed
    localparam logic [dpcm_pkg::RATE_W-1:0] RATE_ALL_ONES = 22'h3FFFFF;

    logic        aclk;
    logic        aresetn;
    logic        cfg_wr_en;
    logic [21:0] cfg_wr_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata;
    logic [1:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [23:0] m_axis_tdata;
    logic [0:0]  m_axis_tuser;

    delta_pcm_sample_channel uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // 10 unit clock
    initial aclk = 1'b0;
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Channel model state
    logic [dpcm_pkg::RATE_W-1:0] mdl_phase_step;
    logic                        mdl_enable;
    logic                        mdl_loop;
    logic [3:0]                  mdl_rate_idx;
    logic                        mdl_low_bit;
    logic [5:0]                  mdl_level;
    logic [7:0]                  mdl_shift;
    logic [dpcm_pkg::ADDR_W-1:0] mdl_addr;
    logic [dpcm_pkg::ADDR_W-1:0] mdl_start;
    logic [dpcm_pkg::BITS_W-1:0] mdl_bits;
    logic [dpcm_pkg::BITS_W-1:0] mdl_length;
    int                          mdl_phase;

    int unsigned period_tab [0:15] = '{428, 380, 340, 320, 286, 254, 226, 214,
                                       190, 160, 142, 128, 106, 85, 72, 54};

    dpcm_pkg::result_t channel_outputs [$];   // predicted result items, oldest first
    logic        src_idle;
    logic        sink_idle;
    int unsigned sink_hold;
    int unsigned error_count;
    int unsigned items_sent;
    int unsigned results_seen;
    int unsigned bits_consumed;
    int unsigned addr_wraps;
    int unsigned rate_settings;

    // Apply one item to the channel model, return the result it causes
    function automatic dpcm_pkg::result_t step_channel(input logic [1:0] op,
                                                       input logic [1:0] ri,
                                                       input logic [7:0] wd,
                                                       input logic [7:0] mb);
        dpcm_pkg::result_t           r;
        logic                        valid;
        logic                        moved;
        logic [dpcm_pkg::RATE_W-1:0] rate;
        logic [2:0]                  pos;
        valid = 1'b0;
        case (op)
            dpcm_pkg::OP_REG_WRITE: begin
                case (ri)
                    dpcm_pkg::REG_RATE: begin
                        mdl_rate_idx = wd[3:0];
                        mdl_loop     = wd[6];
                    end
                    dpcm_pkg::REG_LEVEL: begin
                        mdl_level   = wd[6:1];
                        mdl_low_bit = wd[0];
                    end
                    dpcm_pkg::REG_START: mdl_start = dpcm_pkg::START_BASE + {2'd0, wd, 6'd0};
                    default:             mdl_length = {wd, 4'd1, 3'd0};
                endcase
            end
            dpcm_pkg::OP_CTRL_WRITE: begin
                mdl_enable = wd[4];
                if (!mdl_enable) begin
                    mdl_bits = '0;
                end else if (mdl_bits == '0) begin
                    mdl_addr = mdl_start;
                    mdl_bits = mdl_length;
                end
            end
            dpcm_pkg::OP_TICK: begin
                // phase only runs while data remains
                if (mdl_bits != '0) begin
                    rate = (mdl_phase_step > dpcm_pkg::PHASE_STEP_MAX) ?
                           dpcm_pkg::PHASE_STEP_MAX : mdl_phase_step;
                    mdl_phase = mdl_phase - int'(rate);
                    if (mdl_phase < 0) begin
                        mdl_phase = mdl_phase + int'(period_tab[mdl_rate_idx] << 16);
                        bits_consumed++;
                        // new byte every 8 bits
                        if (mdl_bits[2:0] == 3'd0) begin
                            mdl_shift = mb;
                            if (mdl_addr == dpcm_pkg::ADDR_LAST) begin
                                mdl_addr = dpcm_pkg::ADDR_WRAP;
                                addr_wraps++;
                            end else begin
                                mdl_addr = mdl_addr + 16'd1;
                            end
                        end
                        mdl_bits = mdl_bits - 15'd1;
                        moved = 1'b1;
                        if (mdl_bits == '0) begin
                            if (mdl_loop) begin
                                mdl_addr = mdl_start;
                                mdl_bits = mdl_length;
                            end else begin
                                moved = 1'b0;   // final bit of a one-shot run
                            end
                        end
                        if (moved) begin
                            pos = mdl_bits[2:0] ^ 3'd7;
                            if (mdl_shift[pos]) begin
                                if (mdl_level < dpcm_pkg::LEVEL_MAX)
                                    mdl_level = mdl_level + 6'd1;
                            end else if (mdl_level > dpcm_pkg::LEVEL_MIN) begin
                                mdl_level = mdl_level - 6'd1;
                            end
                        end
                    end
                end
                valid = mdl_enable;
            end
            default: ;
        endcase
        r.sample        = {mdl_level, mdl_low_bit};
        r.sample_valid  = valid;
        r.fetch_address = mdl_addr;
        r.fetch_due     = (mdl_bits != '0) && (mdl_bits[2:0] == 3'd0);
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        if (error_count < PRINT_LIMIT)
            $display("MISMATCH at result %0d, %s: got 0x%0h, want 0x%0h",
                     results_seen, what, got, want);
        error_count++;
    endtask

    // Offer one item, after a random gap when source gaps are on, hold it until accepted
    task automatic send_item(input logic [1:0] op, input logic [1:0] ri,
                             input logic [7:0] wd, input logic [7:0] mb);
        int unsigned gap;
        gap = src_idle ? $urandom_range(0, 19) : 0;
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {6'd0, mb, wd, ri};
        do @(posedge aclk); while (!s_axis_tready);
        channel_outputs.push_back(step_channel(op, ri, wd, mb));
        items_sent++;
    endtask

    // Sample tick with random filler in the unused fields
    task automatic send_tick(input logic [7:0] mb);
        send_item(dpcm_pkg::OP_TICK, 2'($urandom_range(0, 3)),
                  8'($urandom_range(0, 255)), mb);
    endtask

    task automatic send_write(input logic [1:0] op, input logic [1:0] ri,
                              input logic [7:0] wd);
        send_item(op, ri, wd, 8'($urandom_range(0, 255)));
    endtask

    // Stop offering and wait until every predicted item has come back
    task automatic drain_channel();
        s_axis_tvalid <= 1'b0;
        while (channel_outputs.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // Only called with the channel drained
    task automatic write_phase_step(input logic [dpcm_pkg::RATE_W-1:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en      <= 1'b0;
        mdl_phase_step = value;
        rate_settings++;
    endtask

    // Reset rate: idle tick, unused op, register extremes, clamp at the top
    task automatic test_directed_extremes();
        send_tick(8'hFF);
        send_item(OP_UNUSED, 2'd3, 8'hFF, 8'hFF);
        send_write(dpcm_pkg::OP_REG_WRITE, dpcm_pkg::REG_RATE, 8'hFF);
        send_write(dpcm_pkg::OP_REG_WRITE, dpcm_pkg::REG_LEVEL, 8'hFF);
        send_write(dpcm_pkg::OP_REG_WRITE, dpcm_pkg::REG_START, 8'h00);
        send_write(dpcm_pkg::OP_REG_WRITE, dpcm_pkg::REG_LENGTH, 8'h00);
        send_write(dpcm_pkg::OP_CTRL_WRITE, 2'd0, 8'h10);
        send_tick(8'hFF);
        send_tick(8'h00);
        send_write(dpcm_pkg::OP_CTRL_WRITE, 2'd3, 8'hEF);
        send_tick(8'hFF);
        drain_channel();
    endtask

    // Oversized rate, level held at zero, rise from zero, one-shot stop
    task automatic test_directed_level_zero();
        write_phase_step(RATE_ALL_ONES);
        send_write(dpcm_pkg::OP_REG_WRITE, dpcm_pkg::REG_LEVEL, 8'h00);
        send_write(dpcm_pkg::OP_REG_WRITE, dpcm_pkg::REG_RATE, 8'h0F);
        send_write(dpcm_pkg::OP_REG_WRITE, dpcm_pkg::REG_START, 8'hFF);
        send_write(dpcm_pkg::OP_REG_WRITE, dpcm_pkg::REG_LENGTH, 8'h00);
        send_write(dpcm_pkg::OP_CTRL_WRITE, 2'd0, 8'hFF);
        send_tick(8'h00);
        repeat (7) send_tick(8'($urandom_range(0, 255)));
        send_write(dpcm_pkg::OP_CTRL_WRITE, 2'd0, 8'h10);
        send_tick(8'h01);
        send_tick(8'h00);
        drain_channel();
    endtask

    // One long run from the top of memory, through the wrap, to the stop
    task automatic test_address_wrap();
        int unsigned k;
        src_idle  = 1'b0;
        sink_idle = 1'b0;
        write_phase_step(dpcm_pkg::PHASE_STEP_MAX);
        send_write(dpcm_pkg::OP_REG_WRITE, dpcm_pkg::REG_RATE, 8'h0F);
        send_write(dpcm_pkg::OP_REG_WRITE, dpcm_pkg::REG_LEVEL, 8'($urandom_range(0, 255)));
        send_write(dpcm_pkg::OP_REG_WRITE, dpcm_pkg::REG_START, 8'hFF);
        send_write(dpcm_pkg::OP_REG_WRITE, dpcm_pkg::REG_LENGTH, 8'h04);
        send_write(dpcm_pkg::OP_CTRL_WRITE, 2'd0, 8'h10);
        for (k = 0; k < 530; k++) begin
            if (k == 265) begin
                src_idle  = 1'b1;
                sink_idle = 1'b1;
            end
            send_tick(8'($urandom_range(0, 255)));
        end
        drain_channel();
    endtask

    // Random programs: set up the channel, play ticks, sprinkle noise items
    task automatic test_random_programs(input logic [dpcm_pkg::RATE_W-1:0] rate,
                                        input int unsigned count,
                                        input logic src_gaps, input logic sink_gaps);
        int unsigned first;
        int unsigned k;
        int unsigned ticks;
        src_idle  = src_gaps;
        sink_idle = sink_gaps;
        write_phase_step(rate);
        first = items_sent;
        while (items_sent - first < count) begin
            send_write(dpcm_pkg::OP_REG_WRITE, dpcm_pkg::REG_RATE,
                       8'($urandom_range(0, 255)));
            send_write(dpcm_pkg::OP_REG_WRITE, dpcm_pkg::REG_LEVEL,
                       8'($urandom_range(0, 255)));
            send_write(dpcm_pkg::OP_REG_WRITE, dpcm_pkg::REG_START,
                       8'($urandom_range(0, 255)));
            send_write(dpcm_pkg::OP_REG_WRITE, dpcm_pkg::REG_LENGTH,
                       ($urandom_range(0, 9) == 0) ?
                       8'($urandom_range(0, 255)) : 8'($urandom_range(0, 2)));
            send_write(dpcm_pkg::OP_CTRL_WRITE, 2'($urandom_range(0, 3)),
                       8'($urandom_range(0, 255)) | 8'h10);
            ticks = $urandom_range(5, 60);
            for (k = 0; k < ticks; k++) begin
                if ($urandom_range(0, 9) == 0)
                    send_item(2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)),
                              8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
                else
                    send_tick(8'($urandom_range(0, 255)));
            end
            if ($urandom_range(0, 1) == 0)
                send_write(dpcm_pkg::OP_CTRL_WRITE, 2'($urandom_range(0, 3)),
                           8'($urandom_range(0, 255)) & 8'hEF);
            if ($urandom_range(0, 7) == 0) drain_channel();
        end
        drain_channel();
    endtask

    // Receiver holds off for a long stretch while items keep coming
    task automatic test_backpressure();
        src_idle = 1'b0;
        send_write(dpcm_pkg::OP_REG_WRITE, dpcm_pkg::REG_RATE, 8'h4F);
        send_write(dpcm_pkg::OP_REG_WRITE, dpcm_pkg::REG_LENGTH, 8'h01);
        send_write(dpcm_pkg::OP_CTRL_WRITE, 2'd0, 8'h10);
        sink_hold = 150;
        repeat (40) send_tick(8'($urandom_range(0, 255)));
        drain_channel();
        src_idle = 1'b1;
    endtask

    // Result side: random ready gaps, check each item against the model
    initial begin : result_sink
        int unsigned       wait_cycles;
        dpcm_pkg::result_t want;
        while (aresetn !== 1'b1) @(posedge aclk);
        forever begin
            if (sink_hold != 0) begin
                wait_cycles = sink_hold;
                sink_hold   = 0;
            end else begin
                wait_cycles = sink_idle ? $urandom_range(0, 19) : 0;
            end
            if (wait_cycles != 0) begin
                m_axis_tready <= 1'b0;
                repeat (wait_cycles) @(posedge aclk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge aclk); while (!m_axis_tvalid);
            if (channel_outputs.size() == 0) begin
                report_mismatch("item with nothing pending", 32'(m_axis_tdata), 0);
            end else begin
                want = channel_outputs.pop_front();
                if (m_axis_tdata[6:0] != want.sample)
                    report_mismatch("sample", 32'(m_axis_tdata[6:0]), 32'(want.sample));
                if (m_axis_tuser[0] != want.sample_valid)
                    report_mismatch("sample_valid", 32'(m_axis_tuser[0]),
                                    32'(want.sample_valid));
                if (m_axis_tdata[22:7] != want.fetch_address)
                    report_mismatch("fetch_address", 32'(m_axis_tdata[22:7]),
                                    32'(want.fetch_address));
                if (m_axis_tdata[23] != want.fetch_due)
                    report_mismatch("fetch_due", 32'(m_axis_tdata[23]), 32'(want.fetch_due));
            end
            results_seen++;
        end
    end

    // Watchdog on cycles where no item moves on either side
    int unsigned stall_cycles;
    always @(posedge aclk) begin
        if (!aresetn || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("Timeout: no item moved for %0d cycles", STALL_LIMIT);
            $display("Some tests failed");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // Test sequence
    initial begin
        aresetn       <= 1'b0;
        cfg_wr_en     <= 1'b0;
        cfg_wr_data   <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= '0;
        m_axis_tready <= 1'b0;
        src_idle      = 1'b1;
        sink_idle     = 1'b1;
        sink_hold     = 0;
        error_count   = 0;
        items_sent    = 0;
        results_seen  = 0;
        bits_consumed = 0;
        addr_wraps    = 0;
        rate_settings = 0;

        mdl_phase_step = dpcm_pkg::PHASE_STEP_RESET;
        mdl_enable     = 1'b0;
        mdl_loop       = 1'b0;
        mdl_rate_idx   = '0;
        mdl_low_bit    = 1'b0;
        mdl_level      = '0;
        mdl_shift      = '0;
        mdl_addr       = '0;
        mdl_start      = '0;
        mdl_bits       = '0;
        mdl_length     = '0;
        mdl_phase      = 0;

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(posedge aclk);

        test_directed_extremes();
        test_directed_level_zero();
        test_address_wrap();
        test_random_programs(dpcm_pkg::PHASE_STEP_MAX, 140, 1'b1, 1'b1);
        test_backpressure();
        test_random_programs(22'd1, 120, 1'b1, 1'b0);
        test_random_programs(dpcm_pkg::PHASE_STEP_RESET, 140, 1'b0, 1'b1);
        test_random_programs(22'($urandom_range(1, dpcm_pkg::PHASE_STEP_MAX)), 140,
                             1'b1, 1'b1);
        test_random_programs(22'($urandom) & RATE_ALL_ONES, 140, 1'b1, 1'b1);

        drain_channel();
        if (channel_outputs.size() != 0)
            report_mismatch("items never returned", 32'(channel_outputs.size()), 0);

        $display("Run covered %0d items and %0d results over %0d phase step settings",
                 items_sent, results_seen, rate_settings);
        $display("Model consumed %0d data bits with %0d address wraps",
                 bits_consumed, addr_wraps);
        if (error_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
